FILE: rtl/core/c420_pkg.sv
package c420_pkg;

  // widths of the port fields, fixed by the interface
  localparam int unsigned FIELD_BITS = 16;
  localparam int unsigned DIM_BITS   = 13;
  localparam int unsigned COL_BITS   = 12;
  localparam int unsigned ROW_BITS   = 12;
  localparam int unsigned CFG_IDX_BITS = 1;

  // register reset values
  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(1920);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(1080);

  // largest row index
  localparam logic [ROW_BITS-1:0] ROW_CAP = ROW_BITS'(4095);

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

FILE: rtl/core/c420_ram.sv
module c420_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/chroma_444_to_420_box_downsampler.sv
// 4:4:4 to 4:2:0 chroma downsampler. Takes one pixel (Y, U, V) per beat in
// raster order and returns one beat per pixel: luma passed through, and on
// the bottom-right pixel of every 2x2 block the rounded average (sum + 2) / 4
// of each chroma plane with out_chroma_valid set; out_frame_end marks the last
// pixel of the frame. Frame width and height (both even) are to be set
// through the cfg port while the block is idle (not enforced by the block).
// Sustained rate is one pixel per clock while out_ready is high; a pixel
// passes stage 1 (the registered line store read of even-row horizontal
// pair sums), then the output register. Uses low SAMPLE_BITS of each sample.
module chroma_444_to_420_box_downsampler #(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [c420_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [c420_pkg::DIM_BITS-1:0]         cfg_data,

  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [c420_pkg::FIELD_BITS-1:0]       in_y_in,
  input  logic [c420_pkg::FIELD_BITS-1:0]       in_u_in,
  input  logic [c420_pkg::FIELD_BITS-1:0]       in_v_in,

  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [c420_pkg::FIELD_BITS-1:0]       out_y_out,
  output logic                                  out_chroma_valid,
  output logic [c420_pkg::FIELD_BITS-1:0]       out_u_out,
  output logic [c420_pkg::FIELD_BITS-1:0]       out_v_out,
  output logic                                  out_frame_end
);

  import c420_pkg::*;

  localparam int unsigned SB         = SAMPLE_BITS;
  localparam int unsigned PB         = SAMPLE_BITS + 1;
  localparam int unsigned ENTRY_BITS = 2 * PB;
  localparam int unsigned LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int unsigned SLOT_BITS  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned LW         = $clog2(MAX_WIDTH) + 2;

  localparam logic [LW-1:0]        COL_CAP   = LW'(MAX_WIDTH - 1);
  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(LINE_DEPTH - 1);
  localparam logic [COL_BITS-1:0]  COL_MAX   = '1;

  // configuration registers
  logic [DIM_BITS-1:0] frame_width_r;
  logic [DIM_BITS-1:0] frame_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake control
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // position counters
  logic [COL_BITS-1:0]  col_r, col_nxt;
  logic [ROW_BITS-1:0]  row_r, row_nxt;
  logic [SLOT_BITS-1:0] slot_r, slot_nxt;

  // last column and row, clamped
  logic [DIM_BITS-1:0] w_m1;
  logic [DIM_BITS-1:0] h_m1;
  logic [LW-1:0]       last_col;
  logic [ROW_BITS-1:0] last_row;
  logic                row_end;
  logic                frame_done;

  always_comb begin
    w_m1 = (frame_width_r == '0) ? '0 : frame_width_r - DIM_BITS'(1);
    h_m1 = (frame_height_r == '0) ? '0 : frame_height_r - DIM_BITS'(1);
    last_col = (LW'(w_m1) > COL_CAP) ? COL_CAP : LW'(w_m1);
    last_row = (h_m1 > DIM_BITS'(ROW_CAP)) ? ROW_CAP : h_m1[ROW_BITS-1:0];
    row_end    = LW'(col_r) >= last_col;
    frame_done = row_end && (row_r >= last_row);
  end

  // next position; slot tracks (column / 2) modulo the line depth
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (row_end) begin
      col_nxt  = '0;
      slot_nxt = '0;
      row_nxt  = frame_done ? '0 : row_r + ROW_BITS'(1);
    end else begin
      col_nxt = col_r + COL_BITS'(1);
      if (col_r[0]) begin
        slot_nxt = ((col_r == COL_MAX) || (slot_r == SLOT_LAST)) ? '0
                                                                  : slot_r + SLOT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (in_acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  // horizontal pair: first sample held, sum at the odd column
  logic [SB-1:0] pair_first_u_r;
  logic [SB-1:0] pair_first_v_r;
  logic [SB-1:0] u_s;
  logic [SB-1:0] v_s;
  logic [PB-1:0] su;
  logic [PB-1:0] sv;

  assign u_s = in_u_in[SB-1:0];
  assign v_s = in_v_in[SB-1:0];
  assign su  = PB'(pair_first_u_r) + PB'(u_s);
  assign sv  = PB'(pair_first_v_r) + PB'(v_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_first_u_r <= '0;
      pair_first_v_r <= '0;
    end else if (in_acc && !col_r[0]) begin
      pair_first_u_r <= u_s;
      pair_first_v_r <= v_s;
    end
  end

  // line store: even rows write pair sums, odd rows read them back; a cycle
  // does one or the other, and a read never meets a pending write to its slot
  logic                  ls_wr;
  logic                  ls_rd;
  logic [ENTRY_BITS-1:0] ls_rdata;
  logic                  block_done;

  assign ls_wr      = in_acc && col_r[0] && !row_r[0];
  assign block_done = col_r[0] && row_r[0];
  assign ls_rd      = in_acc && block_done;

  c420_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (ls_wr),
    .wr_addr (slot_r),
    .wr_data ({sv, su}),
    .rd_en   (ls_rd),
    .rd_addr (slot_r),
    .rd_data (ls_rdata)
  );

  // stage 1: pixel waiting for the line store read
  logic [SB-1:0] s1_y_r;
  logic          s1_cvalid_r;
  logic          s1_fend_r;
  logic [PB-1:0] s1_su_r;
  logic [PB-1:0] s1_sv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_y_r      <= in_y_in[SB-1:0];
      s1_cvalid_r <= block_done;
      s1_fend_r   <= frame_done;
      s1_su_r     <= su;
      s1_sv_r     <= sv;
    end
  end

  // vertical sum and rounded average
  logic [PB:0]   tu;
  logic [PB:0]   tv;
  logic [SB-1:0] u_avg;
  logic [SB-1:0] v_avg;

  always_comb begin
    tu    = (PB+1)'(ls_rdata[PB-1:0]) + (PB+1)'(s1_su_r) + (PB+1)'(2);
    tv    = (PB+1)'(ls_rdata[ENTRY_BITS-1:PB]) + (PB+1)'(s1_sv_r) + (PB+1)'(2);
    u_avg = tu[PB:2];
    v_avg = tv[PB:2];
  end

  // output register
  logic [FIELD_BITS-1:0] out_y_r;
  logic                  out_cvalid_r;
  logic [FIELD_BITS-1:0] out_u_r;
  logic [FIELD_BITS-1:0] out_v_r;
  logic                  out_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_y_r      <= FIELD_BITS'(s1_y_r);
      out_cvalid_r <= s1_cvalid_r;
      out_u_r      <= s1_cvalid_r ? FIELD_BITS'(u_avg) : '0;
      out_v_r      <= s1_cvalid_r ? FIELD_BITS'(v_avg) : '0;
      out_fend_r   <= s1_fend_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_y_out        = out_y_r;
  assign out_chroma_valid = out_cvalid_r;
  assign out_u_out        = out_u_r;
  assign out_v_out        = out_v_r;
  assign out_frame_end    = out_fend_r;

endmodule
